@@ design/rtff_pkg.sv @@
`timescale 1ns / 1ps
package rtff_pkg;

	localparam int FRAME_BYTES  = 30;
	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS   = 16;
	localparam int POS_W        = $clog2(FRAME_BYTES);
	localparam int LOOP_MAX     = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
	localparam int CNT_W        = $clog2(LOOP_MAX);
	localparam int STEP_W       = 4;
	localparam int CORDIC_W     = 35;
	localparam int ZACC_W       = 32;
	localparam int SQ_W         = 32;

	localparam logic [7:0] HDR_B0 = 8'hAA;
	localparam logic [7:0] HDR_B1 = 8'hFF;
	localparam logic [7:0] HDR_B2 = 8'h03;
	localparam logic [7:0] HDR_B3 = 8'h00;

	localparam logic [15:0] RST_MIN_DIST = 16'd500;
	localparam logic [15:0] RST_MAX_DIST = 16'd6000;
	localparam logic [13:0] RST_MAX_ANG  = 14'd6000;
	localparam logic signed [ZACC_W-1:0] ANG_LIMIT = 32'sd9000;

	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_MIN_DIST = 2'd0;
	localparam logic [1:0] REG_MAX_DIST = 2'd1;
	localparam logic [1:0] REG_MAX_ANG  = 2'd2;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQX,
		OP_SQY,
		OP_SUM,
		OP_SQRT,
		OP_CORDIC,
		OP_ROUND,
		OP_CHECK,
		OP_WRITE
	} rtff_op_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_NO_START,
		COND_LOOP,
		COND_OUT_BUSY
	} rtff_cond_t;

	typedef struct packed {
		rtff_op_t          op;
		rtff_cond_t        cond;
		logic [STEP_W-1:0] target;
	} rtff_uword_t;

	typedef struct packed {
		rtff_op_t         op;
		logic [CNT_W-1:0] cnt;
	} rtff_ctrl_t;

	typedef struct packed {
		logic out_busy;
	} rtff_stat_t;

	typedef struct packed {
		logic [15:0] min_dist;
		logic [15:0] max_dist;
		logic [13:0] max_ang;
	} rtff_cfg_t;

	function automatic rtff_uword_t rtff_ucode(input logic [STEP_W-1:0] step);
		rtff_uword_t w;
		case (step)
			4'd0:    w = '{OP_NOP,    COND_NO_START, 4'd0};
			4'd1:    w = '{OP_LOAD,   COND_NEXT,     4'd0};
			4'd2:    w = '{OP_SQX,    COND_NEXT,     4'd0};
			4'd3:    w = '{OP_SQY,    COND_NEXT,     4'd0};
			4'd4:    w = '{OP_SUM,    COND_NEXT,     4'd0};
			4'd5:    w = '{OP_SQRT,   COND_LOOP,     4'd5};
			4'd6:    w = '{OP_CORDIC, COND_LOOP,     4'd6};
			4'd7:    w = '{OP_ROUND,  COND_NEXT,     4'd0};
			4'd8:    w = '{OP_CHECK,  COND_NEXT,     4'd0};
			4'd9:    w = '{OP_WRITE,  COND_OUT_BUSY, 4'd9};
			4'd10:   w = '{OP_NOP,    COND_ALWAYS,   4'd0};
			default: w = '{OP_NOP,    COND_ALWAYS,   4'd0};
		endcase
		return w;
	endfunction

	function automatic logic signed [ZACC_W-1:0] rtff_atan(input logic [4:0] i);
		logic signed [ZACC_W-1:0] v;
		case (i)
			5'd0:    v = 32'sd294912000;
			5'd1:    v = 32'sd174096719;
			5'd2:    v = 32'sd91987925;
			5'd3:    v = 32'sd46694507;
			5'd4:    v = 32'sd23437865;
			5'd5:    v = 32'sd11730358;
			5'd6:    v = 32'sd5866610;
			5'd7:    v = 32'sd2933484;
			5'd8:    v = 32'sd1466764;
			5'd9:    v = 32'sd733385;
			5'd10:   v = 32'sd366693;
			5'd11:   v = 32'sd183346;
			5'd12:   v = 32'sd91673;
			5'd13:   v = 32'sd45837;
			5'd14:   v = 32'sd22918;
			5'd15:   v = 32'sd11459;
			5'd16:   v = 32'sd5730;
			5'd17:   v = 32'sd2865;
			5'd18:   v = 32'sd1432;
			5'd19:   v = 32'sd716;
			5'd20:   v = 32'sd358;
			5'd21:   v = 32'sd179;
			5'd22:   v = 32'sd90;
			5'd23:   v = 32'sd45;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ design/rtff_if.sv @@
`timescale 1ns / 1ps
interface rtff_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface rtff_out_if;
	logic               valid;
	logic               ready;
	logic               detected;
	logic signed [14:0] angle_centideg;
	logic [15:0]        distance_mm;
	logic signed [15:0] target_x_mm;
	logic signed [15:0] target_y_mm;

	modport source(output valid, output detected, output angle_centideg,
		output distance_mm, output target_x_mm, output target_y_mm, input ready);
	modport sink(input valid, input detected, input angle_centideg,
		input distance_mm, input target_x_mm, input target_y_mm, output ready);
endinterface

@@ design/rtff_regs.sv @@
`timescale 1ns / 1ps
module rtff_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rtff_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output rtff_pkg::rtff_cfg_t         cfg
);
	import rtff_pkg::*;

	logic [15:0] min_dist_q;
	logic [15:0] max_dist_q;
	logic [13:0] max_ang_q;
	logic        wr_en;
	logic [1:0]  idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= RST_MIN_DIST;
			max_dist_q <= RST_MAX_DIST;
			max_ang_q  <= RST_MAX_ANG;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_DIST: min_dist_q <= pwdata[15:0];
				REG_MAX_DIST: max_dist_q <= pwdata[15:0];
				REG_MAX_ANG:  max_ang_q  <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_DIST: prdata = {16'd0, min_dist_q};
			REG_MAX_DIST: prdata = {16'd0, max_dist_q};
			REG_MAX_ANG:  prdata = {18'd0, max_ang_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg = '{min_dist: min_dist_q, max_dist: max_dist_q, max_ang: max_ang_q};
endmodule

@@ design/rtff_parser.sv @@
`timescale 1ns / 1ps
module rtff_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  rx_byte,
	output logic        start,
	output logic [15:0] raw_x,
	output logic [15:0] raw_y
);
	import rtff_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [23:0]      hdr_q;
	logic [15:0]      raw_x_q;
	logic [15:0]      raw_y_q;
	logic             hdr_ok;
	logic             last;

	assign hdr_ok = (hdr_q == {HDR_B0, HDR_B1, HDR_B2}) && (rx_byte == HDR_B3);
	assign last   = (pos_q == POS_W'(FRAME_BYTES - 1));
	assign start  = accept && last;
	assign raw_x  = raw_x_q;
	assign raw_y  = raw_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= '0;
			raw_x_q <= '0;
			raw_y_q <= '0;
		end else if (accept) begin
			if (pos_q < POS_W'(3)) begin
				hdr_q <= {hdr_q[15:0], rx_byte};
				pos_q <= pos_q + 1'b1;
			end else if (pos_q == POS_W'(3)) begin
				pos_q <= hdr_ok ? POS_W'(4) : '0;
			end else begin
				if (pos_q == POS_W'(4)) raw_x_q[7:0]  <= rx_byte;
				if (pos_q == POS_W'(5)) raw_x_q[15:8] <= rx_byte;
				if (pos_q == POS_W'(6)) raw_y_q[7:0]  <= rx_byte;
				if (pos_q == POS_W'(7)) raw_y_q[15:8] <= rx_byte;
				pos_q <= last ? '0 : pos_q + 1'b1;
			end
		end
	end
endmodule

@@ design/rtff_sequencer.sv @@
`timescale 1ns / 1ps
module rtff_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rtff_pkg::rtff_stat_t stat,
	output rtff_pkg::rtff_ctrl_t ctrl,
	output logic                 idle
);
	import rtff_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [CNT_W-1:0]  cnt_last;
	rtff_uword_t       uw;
	logic              jump;
	logic              at_last;

	always_comb begin
		uw       = rtff_ucode(step_q);
		cnt_last = (uw.op == OP_SQRT) ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(CORDIC_STEPS - 1);
		at_last  = (cnt_q == cnt_last);
		case (uw.cond)
			COND_NEXT:     jump = 1'b0;
			COND_ALWAYS:   jump = 1'b1;
			COND_NO_START: jump = !start;
			COND_LOOP:     jump = !at_last;
			COND_OUT_BUSY: jump = stat.out_busy;
			default:       jump = 1'b0;
		endcase
		step_d = jump ? uw.target : step_q + 1'b1;
		if ((uw.op == OP_SQRT || uw.op == OP_CORDIC) && !at_last) begin
			cnt_d = cnt_q + 1'b1;
		end else begin
			cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cnt_q  <= '0;
		end else begin
			step_q <= step_d;
			cnt_q  <= cnt_d;
		end
	end

	assign ctrl = '{op: uw.op, cnt: cnt_q};
	assign idle = (step_q == '0);
endmodule

@@ design/rtff_datapath.sv @@
`timescale 1ns / 1ps
module rtff_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtff_pkg::rtff_ctrl_t ctrl,
	input  rtff_pkg::rtff_cfg_t  cfg,
	input  logic [15:0]          raw_x,
	input  logic [15:0]          raw_y,
	output rtff_pkg::rtff_stat_t stat,
	rtff_out_if.source           res
);
	import rtff_pkg::*;

	logic signed [15:0]         x_q;
	logic signed [15:0]         y_q;
	logic [14:0]                ax_q;
	logic [14:0]                ay_q;
	logic [29:0]                prod_q;
	logic [SQ_W-1:0]            acc_q;
	logic [SQ_W-1:0]            rem_q;
	logic [SQ_W-1:0]            root_q;
	logic [SQ_W-1:0]            bit_q;
	logic signed [CORDIC_W-1:0] cx_q;
	logic signed [CORDIC_W-1:0] cy_q;
	logic signed [ZACC_W-1:0]   z_q;
	logic signed [14:0]         ang_q;
	logic                       hit_q;
	logic                       out_valid_q;
	logic                       det_q;
	logic signed [14:0]         ang_out_q;
	logic [15:0]                dist_out_q;
	logic signed [15:0]         held_x_q;
	logic signed [15:0]         held_y_q;

	logic [14:0]                mag_x;
	logic [14:0]                mag_y;
	logic [14:0]                mul_a;
	logic [29:0]                mul_p;
	logic [SQ_W-1:0]            trial;
	logic signed [CORDIC_W-1:0] dx;
	logic signed [CORDIC_W-1:0] dy;
	logic signed [CORDIC_W-1:0] cx_init;
	logic signed [CORDIC_W-1:0] cy_mag;
	logic signed [ZACC_W-1:0]   atan_v;
	logic signed [ZACC_W-1:0]   z_rnd;
	logic signed [14:0]         ang_clamp;
	logic [14:0]                ang_abs;
	logic [15:0]                dist_mm;
	logic                       out_free;

	assign mag_x    = raw_x[14:0];
	assign mag_y    = raw_y[14:0];
	assign mul_a    = (ctrl.op == OP_SQX) ? ax_q : ay_q;
	assign mul_p    = mul_a * mul_a;
	assign trial    = root_q + bit_q;
	assign dx       = cx_q >>> ctrl.cnt;
	assign dy       = cy_q >>> ctrl.cnt;
	assign atan_v   = rtff_atan(5'(ctrl.cnt));
	assign cx_init  = CORDIC_W'($signed({1'b0, ay_q, 16'd0}));
	assign cy_mag   = CORDIC_W'($signed({1'b0, ax_q, 16'd0}));
	assign z_rnd    = (z_q + 32'sd32768) >>> 16;
	assign dist_mm  = root_q[15:0];
	assign ang_abs  = ang_q[14] ? 15'(-ang_q) : ang_q;
	assign out_free = !out_valid_q || res.ready;

	always_comb begin
		if (ax_q == '0) begin
			ang_clamp = '0;
		end else if (z_rnd > ANG_LIMIT) begin
			ang_clamp = 15'(ANG_LIMIT);
		end else if (z_rnd < -ANG_LIMIT) begin
			ang_clamp = 15'(-ANG_LIMIT);
		end else begin
			ang_clamp = z_rnd[14:0];
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				ax_q <= mag_x;
				ay_q <= mag_y;
				x_q  <= raw_x[15] ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
				y_q  <= raw_y[15] ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
			end
			OP_SQX: begin
				prod_q <= mul_p;
				cx_q   <= cx_init;
				cy_q   <= x_q[15] ? -cy_mag : cy_mag;
				z_q    <= '0;
			end
			OP_SQY: begin
				acc_q  <= SQ_W'(prod_q);
				prod_q <= mul_p;
			end
			OP_SUM: begin
				rem_q  <= acc_q + SQ_W'(prod_q);
				root_q <= '0;
				bit_q  <= SQ_W'(1) << 30;
			end
			OP_SQRT: begin
				if (rem_q >= trial) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_CORDIC: begin
				if (!cy_q[CORDIC_W-1]) begin
					cx_q <= cx_q + dy;
					cy_q <= cy_q - dx;
					z_q  <= z_q + atan_v;
				end else begin
					cx_q <= cx_q - dy;
					cy_q <= cy_q + dx;
					z_q  <= z_q - atan_v;
				end
			end
			OP_ROUND: begin
				ang_q <= ang_clamp;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
			held_x_q    <= '0;
			held_y_q    <= '0;
		end else begin
			if (ctrl.op == OP_CHECK) begin
				hit_q <= (dist_mm >= cfg.min_dist) && (dist_mm <= cfg.max_dist) &&
					({1'b0, ang_abs[13:0]} <= {1'b0, cfg.max_ang}) && !ang_abs[14];
			end
			if (ctrl.op == OP_WRITE && out_free) begin
				out_valid_q <= 1'b1;
				if (hit_q) begin
					held_x_q <= x_q;
					held_y_q <= y_q;
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_WRITE && out_free) begin
			det_q      <= hit_q;
			ang_out_q  <= hit_q ? ang_q : '0;
			dist_out_q <= hit_q ? dist_mm : '0;
		end
	end

	assign stat.out_busy     = !out_free;
	assign res.valid         = out_valid_q;
	assign res.detected      = det_q;
	assign res.angle_centideg = ang_out_q;
	assign res.distance_mm   = dist_out_q;
	assign res.target_x_mm   = held_x_q;
	assign res.target_y_mm   = held_y_q;
endmodule

@@ design/radar_target_frame_filter_core.sv @@
`timescale 1ns / 1ps
// channel  dir  payload                                          handshake
// rx       in   rx_byte                                          valid/ready
// res      out  detected angle_centideg distance_mm target_x/y   valid/ready
// cfg      in   three window registers at 0x0 0x4 0x8            apb, pready tied high
//
// bytes are taken one a cycle while the sequencer sits at its idle step
// the last byte of a frame starts a microprogram: four setup steps,
// 16 square root steps, 16 cordic steps and four steps to round, compare and write
// rx ready stays low for that run, plus any cycles the write step waits on res ready
// a result waiting in the output register holds the next frame at its write step
// reset is asynchronous, active low, and leaves the window at 500/6000 mm and 60 deg
module radar_target_frame_filter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rtff_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	rtff_in_if.sink                      rx,
	rtff_out_if.source                   res
);
	import rtff_pkg::*;

	rtff_cfg_t   cfg;
	rtff_ctrl_t  ctrl;
	rtff_stat_t  stat;
	logic        idle;
	logic        accept;
	logic        start;
	logic [15:0] raw_x;
	logic [15:0] raw_y;

	assign rx.ready = idle;
	assign accept   = rx.valid && rx.ready;

	rtff_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rtff_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx.rx_byte),
		.start   (start),
		.raw_x   (raw_x),
		.raw_y   (raw_y)
	);

	rtff_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctrl   (ctrl),
		.idle   (idle)
	);

	rtff_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg),
		.raw_x  (raw_x),
		.raw_y  (raw_y),
		.stat   (stat),
		.res    (res)
	);
endmodule
